// File: hw/rtl/cdmc_pkg.sv
// ----------------------------------------------------------------------------
// Civil date / minute codec package
// Shared stage depths, mode codes and the records passed between the
// encode, split and civil-date pipelines.
// ----------------------------------------------------------------------------
package cdmc_pkg;

    // Mode codes carried with each transfer
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Register stages of each pipeline
    localparam int FRONT_STAGES = 3;   // encode and time-of-day split
    localparam int CIVIL_STAGES = 8;   // day number to year/month/day

    // Day number and time of day out of the split pipeline
    typedef struct packed {
        logic signed [22:0] day;
        logic [4:0]         hour;
        logic [5:0]         minute;
    } split_t;

    // Calendar fields out of the civil-date pipeline
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        range_error;
    } civil_t;

    // Control bits that travel with each item
    typedef struct packed {
        logic vld;
        logic mode;
    } ctl_t;

    // Front-end results held while the civil-date pipeline works
    typedef struct packed {
        logic [32:0] count;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } side_t;

endpackage

// File: hw/rtl/cdmc_encode.sv
// ----------------------------------------------------------------------------
// Date to minute count encoder
// Three-stage pipeline: Julian day terms, day offset, scale to minutes.
// ----------------------------------------------------------------------------
module cdmc_encode
    import cdmc_pkg::*;
(
    input  logic               clk,
    input  logic [13:0]        year_in,
    input  logic [3:0]         month_in,
    input  logic [4:0]         day_in,
    input  logic [4:0]         hour_in,
    input  logic [5:0]         minute_in,
    output logic signed [32:0] count
);

    // x / 25 == (x * 5243) >> 17, exact for x below 43690
    localparam logic [12:0] RECIP_25   = 13'd5243;
    localparam logic [25:0] DAY_OFFSET = 26'd2484321;   // 32045 + 2452276

    // (153 * m + 2) / 5 with m the March-based month index
    function automatic logic [8:0] month_term(input logic [3:0] mon);
        logic [8:0] term;
        case (mon)
            4'd0:    term = 9'd275;
            4'd1:    term = 9'd306;
            4'd2:    term = 9'd337;
            4'd3:    term = 9'd0;
            4'd4:    term = 9'd31;
            4'd5:    term = 9'd61;
            4'd6:    term = 9'd92;
            4'd7:    term = 9'd122;
            4'd8:    term = 9'd153;
            4'd9:    term = 9'd184;
            4'd10:   term = 9'd214;
            4'd11:   term = 9'd245;
            4'd12:   term = 9'd275;
            4'd13:   term = 9'd306;
            4'd14:   term = 9'd337;
            default: term = 9'd367;
        endcase
        return term;
    endfunction

    logic               early;
    logic [14:0]        y_next;
    logic [25:0]        p100;
    logic [25:0]        p400;
    logic [14:0]        y_reg;
    logic [7:0]         q100_reg;
    logic [5:0]         q400_reg;
    logic [9:0]         base_reg;
    logic [10:0]        hm_reg;
    logic [25:0]        pos_sum;
    logic signed [23:0] days_reg;
    logic [10:0]        hm2_reg;
    logic signed [35:0] prod_min;
    logic [32:0]        count_next;
    logic signed [32:0] count_reg;

    // Stage 1: March-based year, century terms
    always_comb
    begin
        early  = (month_in <= 4'd2);
        y_next = 15'(year_in) + 15'd4800 - 15'(early);
        p100   = 26'(y_next[14:2]) * 26'(RECIP_25);
        p400   = 26'(y_next[14:4]) * 26'(RECIP_25);
    end

    // Stage 2: day offset from the epoch
    always_comb
    begin
        pos_sum = 26'(y_reg) * 26'd365 + 26'(y_reg[14:2]) + 26'(q400_reg)
                  + 26'(base_reg) - 26'(q100_reg);
    end

    // Stage 3: days to minutes, add time of day (wraps to 33 bits)
    always_comb
    begin
        prod_min   = 36'(days_reg) * 36'sd1440;
        count_next = prod_min[32:0] + 33'(hm2_reg);
    end

    always_ff @(posedge clk)
    begin
        y_reg     <= y_next;
        q100_reg  <= p100[24:17];
        q400_reg  <= p400[22:17];
        base_reg  <= 10'(day_in) + 10'(month_term(month_in));
        hm_reg    <= 11'(hour_in) * 11'd60 + 11'(minute_in);
        days_reg  <= 24'(pos_sum - DAY_OFFSET);
        hm2_reg   <= hm_reg;
        count_reg <= count_next;
    end

    assign count = count_reg;

endmodule

// File: hw/rtl/cdmc_split.sv
// ----------------------------------------------------------------------------
// Minute count splitter
// Floor division of the signed minute count by 1440, then hour and minute
// of the remainder. Three register stages.
// ----------------------------------------------------------------------------
module cdmc_split
    import cdmc_pkg::*;
(
    input  logic               clk,
    input  logic signed [32:0] count,
    output split_t             split
);

    // Whole days added so the biased count is never negative
    localparam logic [23:0] BIAS_DAYS = 24'd2982617;
    localparam logic [33:0] BIAS_MIN  = 34'd4294968480;   // BIAS_DAYS * 1440
    // floor(2^35 / 45): estimate low by at most one
    localparam logic [29:0] RECIP_45  = 30'd763549741;
    // x / 15 == (x * 1093) >> 14 for x below 1489
    localparam logic [10:0] RECIP_15  = 11'd1093;

    logic [33:0]        biased;
    logic [58:0]        prod45;
    logic [28:0]        x_reg;
    logic [4:0]         lo_reg;
    logic [23:0]        qe_reg;
    logic [28:0]        r_full;
    logic               over;
    logic [23:0]        q_fix;
    logic [6:0]         r_fix;
    logic signed [24:0] day_full;
    logic signed [22:0] day_reg;
    logic [10:0]        rem_reg;
    logic [19:0]        hp;
    logic [10:0]        mi_full;
    split_t             split_reg;

    // Stage 1: bias, divide by 32 by shift, estimate quotient by 45
    always_comb
    begin
        biased = 34'(count) + BIAS_MIN;
        prod45 = 59'(biased[33:5]) * 59'(RECIP_45);
    end

    // Stage 2: correct the estimate, remove the bias
    always_comb
    begin
        r_full   = x_reg - 29'(qe_reg) * 29'd45;
        over     = (r_full[6:0] >= 7'd45);
        q_fix    = qe_reg + 24'(over);
        r_fix    = over ? (r_full[6:0] - 7'd45) : r_full[6:0];
        day_full = $signed({1'b0, q_fix}) - $signed({1'b0, BIAS_DAYS});
    end

    // Stage 3: hour and minute of the minute of day
    always_comb
    begin
        hp      = 20'(rem_reg[10:2]) * 20'(RECIP_15);
        mi_full = rem_reg - 11'(hp[18:14]) * 11'd60;
    end

    always_ff @(posedge clk)
    begin
        x_reg            <= biased[33:5];
        lo_reg           <= biased[4:0];
        qe_reg           <= prod45[58:35];
        day_reg          <= day_full[22:0];
        rem_reg          <= {r_fix[5:0], lo_reg};
        split_reg.day    <= day_reg;
        split_reg.hour   <= hp[18:14];
        split_reg.minute <= mi_full[5:0];
    end

    assign split = split_reg;

endmodule

// File: hw/rtl/cdmc_civil.sv
// ----------------------------------------------------------------------------
// Day number to civil date
// Eight register stages through the 400/100-year and 4-year cycles and the
// month span; all divisions truncate toward zero.
// ----------------------------------------------------------------------------
module cdmc_civil
    import cdmc_pkg::*;
(
    input  logic               clk,
    input  logic signed [22:0] day_num,
    output civil_t             civil
);

    localparam logic [22:0] RECIP_D400 = 23'd7525901;   // floor(2^40 / 146097)
    localparam logic [19:0] RECIP_D4   = 20'd734936;    // floor(2^30 / 1461)
    localparam logic [11:0] RECIP_153  = 12'd3427;      // exact >> 19 below 4096
    localparam logic [11:0] RECIP_5    = 12'd3277;      // exact >> 14 below 4096

    // stage 1
    logic signed [25:0] n1;
    logic [25:0]        mag1_full;
    logic [46:0]        prod1;
    logic signed [23:0] d1_reg;
    logic [23:0]        mag1_reg;
    logic [6:0]         qe1_reg;
    logic               neg1_reg;
    // stage 2
    logic [23:0]        r1;
    logic [7:0]         q1;
    logic signed [7:0]  t1_next;
    logic signed [23:0] d2a_reg;
    logic signed [7:0]  t1_reg;
    // stage 3
    logic signed [24:0] d2_full;
    logic signed [19:0] d2_reg;
    logic signed [14:0] ycent_reg;
    // stage 4
    logic signed [21:0] n2;
    logic [21:0]        mag2_full;
    logic [38:0]        prod2;
    logic signed [19:0] d2b_reg;
    logic signed [14:0] ycent2_reg;
    logic [18:0]        mag2_reg;
    logic [7:0]         qe2_reg;
    logic               neg2_reg;
    // stage 5
    logic [18:0]        r2;
    logic [8:0]         q2;
    logic signed [8:0]  t2_next;
    logic signed [19:0] d2c_reg;
    logic signed [14:0] ycent3_reg;
    logic signed [8:0]  t2_reg;
    // stage 6
    logic signed [20:0] d3_full;
    logic signed [11:0] d3_reg;
    logic signed [14:0] y_reg;
    // stage 7
    logic signed [13:0] n3;
    logic [13:0]        mag3_full;
    logic [23:0]        prod3;
    logic signed [5:0]  q3;
    logic signed [11:0] d3b_reg;
    logic signed [14:0] y2_reg;
    logic signed [5:0]  m_reg;
    // stage 8
    logic signed [12:0] n4;
    logic [12:0]        mag4_full;
    logic [23:0]        prod4;
    logic signed [12:0] q4;
    logic signed [12:0] d4;
    logic               late;
    logic signed [14:0] y_adj;
    logic signed [5:0]  mon;
    civil_t             civil_next;
    civil_t             civil_reg;

    // Stage 1: 4 * (d + 36525), magnitude, quotient estimate by 146097
    always_comb
    begin
        n1        = (26'(day_num) + 26'sd767681) <<< 2;
        mag1_full = n1[25] ? 26'(-n1) : 26'(n1);
        prod1     = 47'(mag1_full[23:0]) * 47'(RECIP_D400);
    end

    // Stage 2: correct estimate, century counter t = trunc - 1
    always_comb
    begin
        r1      = mag1_reg - 24'(qe1_reg) * 24'd146097;
        q1      = 8'(qe1_reg) + 8'(r1 >= 24'd146097);
        t1_next = neg1_reg ? $signed(~q1) : $signed(q1 - 8'd1);
    end

    // Stage 3: remove whole centuries
    always_comb
    begin
        d2_full = 25'(d2a_reg) - 25'(t1_reg) * 25'sd36524 - 25'(t1_reg >>> 2);
    end

    // Stage 4: 4 * (d + 366), magnitude, quotient estimate by 1461
    always_comb
    begin
        n2        = (22'(d2_reg) + 22'sd366) <<< 2;
        mag2_full = n2[21] ? 22'(-n2) : 22'(n2);
        prod2     = 39'(mag2_full[18:0]) * 39'(RECIP_D4);
    end

    // Stage 5: correct estimate, year-in-century counter
    always_comb
    begin
        r2      = mag2_reg - 19'(qe2_reg) * 19'd1461;
        q2      = 9'(qe2_reg) + 9'(r2 >= 19'd1461);
        t2_next = neg2_reg ? $signed(~q2) : $signed(q2 - 9'd1);
    end

    // Stage 6: remove whole years
    always_comb
    begin
        d3_full = 21'(d2c_reg) - 21'(t2_reg) * 21'sd365 - 21'(t2_reg >>> 2);
    end

    // Stage 7: March-based month index
    always_comb
    begin
        n3        = 14'(d3_reg) * 14'sd5 + 14'sd2;
        mag3_full = n3[13] ? 14'(-n3) : 14'(n3);
        prod3     = 24'(mag3_full[11:0]) * 24'(RECIP_153);
        q3        = $signed({1'b0, prod3[23:19]});
        q3        = n3[13] ? -q3 : q3;
    end

    // Stage 8: day of month, January/February roll into next year
    always_comb
    begin
        n4        = 13'(m_reg) * 13'sd153 + 13'sd2;
        mag4_full = n4[12] ? 13'(-n4) : 13'(n4);
        prod4     = 24'(mag4_full[11:0]) * 24'(RECIP_5);
        q4        = $signed({3'b000, prod4[23:14]});
        q4        = n4[12] ? -q4 : q4;
        d4        = 13'(d3b_reg) - q4;
        late      = (m_reg > 6'sd9);
        y_adj     = y2_reg + (late ? 15'sd1 : 15'sd0);
        mon       = m_reg + 6'sd3 - (late ? 6'sd12 : 6'sd0);

        civil_next.year        = y_adj[13:0];
        civil_next.month       = mon[3:0];
        civil_next.day         = 5'(d4 + 13'sd1);
        civil_next.range_error = (y_adj < 15'sd1) || (y_adj > 15'sd9999);
    end

    always_ff @(posedge clk)
    begin
        d1_reg     <= 24'(day_num) + 24'sd731156;
        mag1_reg   <= mag1_full[23:0];
        qe1_reg    <= prod1[46:40];
        neg1_reg   <= n1[25];

        d2a_reg    <= d1_reg;
        t1_reg     <= t1_next;

        d2_reg     <= d2_full[19:0];
        ycent_reg  <= 15'(t1_reg) * 15'sd100;

        d2b_reg    <= d2_reg;
        ycent2_reg <= ycent_reg;
        mag2_reg   <= mag2_full[18:0];
        qe2_reg    <= prod2[37:30];
        neg2_reg   <= n2[21];

        d2c_reg    <= d2b_reg;
        ycent3_reg <= ycent2_reg;
        t2_reg     <= t2_next;

        d3_reg     <= d3_full[11:0];
        y_reg      <= ycent3_reg + 15'(t2_reg);

        d3b_reg    <= d3_reg;
        y2_reg     <= y_reg;
        m_reg      <= q3;

        civil_reg  <= civil_next;
    end

    assign civil = civil_reg;

endmodule

// File: hw/rtl/civil_date_minute_codec_unit.sv
// ----------------------------------------------------------------------------
// Civil date / minute codec
// Converts a Gregorian date and time to signed minutes since 2002-01-01 00:00
// (mode 0) or back (mode 1). One transfer is taken in every clock cycle:
// busy never rises. Each result appears on the output ports for a single
// cycle with done high; the depth is set by the decode path, a chain of
// constant divisions (1440, 146097, 1461, 153, 5), the first three each cut
// into a multiply-by-reciprocal stage and a correction stage. The
// receiver must take every result as it comes. Fields that do not apply to
// the selected mode read zero; range_error flags a decoded year outside
// 1..9999.
// ----------------------------------------------------------------------------
module civil_date_minute_codec_unit
    import cdmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [13:0]        year_in,
    input  logic [3:0]         month_in,
    input  logic [4:0]         day_in,
    input  logic [4:0]         hour_in,
    input  logic [5:0]         minute_in,
    input  logic signed [32:0] count_in,
    output logic               done,
    output logic signed [32:0] count_out,
    output logic [13:0]        year_out,
    output logic [3:0]         month_out,
    output logic [4:0]         day_out,
    output logic [4:0]         hour_out,
    output logic [5:0]         minute_out,
    output logic               range_error
);

    localparam int CTL_DEPTH = FRONT_STAGES + CIVIL_STAGES;
    localparam int LATENCY   = CTL_DEPTH + 1;

    logic signed [32:0] enc_count;
    split_t             split;
    civil_t             civil;
    ctl_t               ctl_reg [CTL_DEPTH];
    side_t              side_reg [CIVIL_STAGES];
    ctl_t               ctl_last;
    side_t              side_last;
    logic               done_reg;
    logic signed [32:0] count_reg;
    logic [13:0]        year_reg;
    logic [3:0]         month_reg;
    logic [4:0]         day_reg;
    logic [4:0]         hour_reg;
    logic [5:0]         minute_reg;
    logic               err_reg;

    // The pipeline never stalls
    assign busy = 1'b0;

    cdmc_encode u_encode (
        .clk       (clk),
        .year_in   (year_in),
        .month_in  (month_in),
        .day_in    (day_in),
        .hour_in   (hour_in),
        .minute_in (minute_in),
        .count     (enc_count)
    );

    cdmc_split u_split (
        .clk   (clk),
        .count (count_in),
        .split (split)
    );

    cdmc_civil u_civil (
        .clk     (clk),
        .day_num (split.day),
        .civil   (civil)
    );

    assign ctl_last  = ctl_reg[CTL_DEPTH-1];
    assign side_last = side_reg[CIVIL_STAGES-1];

    // Valid and mode travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CTL_DEPTH; i++)
            begin
                ctl_reg[i] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg[0].vld  <= start && !busy;
            ctl_reg[0].mode <= mode;
            for (int i = 1; i < CTL_DEPTH; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            done_reg <= ctl_last.vld;
        end
    end

    // Hold encode count and time of day while the date is recovered
    always_ff @(posedge clk)
    begin
        side_reg[0].count  <= enc_count;
        side_reg[0].hour   <= split.hour;
        side_reg[0].minute <= split.minute;
        for (int i = 1; i < CIVIL_STAGES; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // Output register: pick the fields of the selected mode
    always_ff @(posedge clk)
    begin
        if (ctl_last.mode == MODE_DECODE)
        begin
            count_reg  <= '0;
            year_reg   <= civil.year;
            month_reg  <= civil.month;
            day_reg    <= civil.day;
            hour_reg   <= side_last.hour;
            minute_reg <= side_last.minute;
            err_reg    <= civil.range_error;
        end
        else
        begin
            count_reg  <= side_last.count;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            err_reg    <= 1'b0;
        end
    end

    assign done        = done_reg;
    assign count_out   = count_reg;
    assign year_out    = year_reg;
    assign month_out   = month_reg;
    assign day_out     = day_reg;
    assign hour_out    = hour_reg;
    assign minute_out  = minute_reg;
    assign range_error = err_reg;

`ifndef SYNTHESIS
    // Every result stems from a transfer taken a fixed depth earlier
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a matching transfer");

    // Every transfer yields exactly one result after the pipeline depth
    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("transfer lost in the pipeline");

    // Floor split of the minute count keeps time of day in range
    a_time_of_day: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hour_out < 5'd24) && (minute_out < 6'd60))
        else $error("time of day out of range");

    // Range flag only comes from decode, where the count reads zero
    a_error_decode_only: assert property (@(posedge clk) disable iff (!rst_n)
        done && range_error |-> (count_out == 33'sd0))
        else $error("range flag with an encode result");
`endif

endmodule
